>>> sv/tcp_receive_window_select_assert.svh
// assertion macros for the receive window select block
// expects signals named clk and rst in the scope of use
`ifndef TCP_RECEIVE_WINDOW_SELECT_ASSERT_SVH
`define TCP_RECEIVE_WINDOW_SELECT_ASSERT_SVH

// same-cycle implication
`define TRWS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trws assertion failed");

// next-cycle implication
`define TRWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trws assertion failed");

`endif

>>> sv/trws_pkg.sv
// shared types and constants for the receive window select block
// used by the register file, the serial remainder unit and the top level
package trws_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_WINDOW_SCALE   = 3'd0;
  localparam logic [2:0] REG_SIGNED_WA      = 3'd1;
  localparam logic [2:0] REG_WINDOW_CLAMP   = 3'd2;
  localparam logic [2:0] REG_ADV_MSS        = 3'd3;
  localparam logic [2:0] REG_INIT_WINDOW    = 3'd4;
  localparam logic [2:0] REG_INIT_THRESHOLD = 3'd5;

  // register reset values
  localparam logic [29:0] RESET_CLAMP      = 30'd65535;
  localparam logic [15:0] RESET_ADV_MSS    = 16'd1460;
  localparam logic [29:0] RESET_INIT_WIN   = 30'd65535;
  localparam logic [29:0] RESET_INIT_THR   = 30'd65535;

  // header limits
  localparam logic [15:0] HEADER_WINDOW_MAX = 16'hFFFF;
  localparam logic [15:0] SIGNED_WINDOW_MAX = 16'h7FFF;

  // threshold cap under pressure is four times own mss
  localparam int PRESSURE_MSS_SHIFT = 2;

  // threshold never grows past its reset value, so space fits 16 bits
  localparam int SPACE_W   = 16;
  localparam int DIV_STEPS = SPACE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // configuration seen by the datapath
  typedef struct packed {
    logic [3:0]  scale;
    logic        signed_wa;
    logic [29:0] clamp;
    logic [15:0] adv_mss;
  } cfg_t;

  // remainder unit handshake
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> sv/trws_cfg.sv
// configuration register file on an apb-style port
// depends on trws_pkg for register indexes and reset values
module trws_cfg
  import trws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [3:0]  window_scale;
  logic        signed_wa;
  logic [29:0] clamp_limit;
  logic [15:0] adv_mss;
  logic [29:0] init_window;
  logic [29:0] init_threshold;
  logic        wr_en;
  logic [2:0]  index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_scale   <= 4'd0;
      signed_wa      <= 1'b0;
      clamp_limit    <= RESET_CLAMP;
      adv_mss        <= RESET_ADV_MSS;
      init_window    <= RESET_INIT_WIN;
      init_threshold <= RESET_INIT_THR;
    end else if (wr_en) begin
      case (index)
        REG_WINDOW_SCALE:   window_scale   <= pwdata[3:0];
        REG_SIGNED_WA:      signed_wa      <= pwdata[0];
        REG_WINDOW_CLAMP:   clamp_limit    <= pwdata[29:0];
        REG_ADV_MSS:        adv_mss        <= pwdata[15:0];
        REG_INIT_WINDOW:    init_window    <= pwdata[29:0];
        REG_INIT_THRESHOLD: init_threshold <= pwdata[29:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (index)
      REG_WINDOW_SCALE:   prdata = {28'd0, window_scale};
      REG_SIGNED_WA:      prdata = {31'd0, signed_wa};
      REG_WINDOW_CLAMP:   prdata = {2'd0, clamp_limit};
      REG_ADV_MSS:        prdata = {16'd0, adv_mss};
      REG_INIT_WINDOW:    prdata = {2'd0, init_window};
      REG_INIT_THRESHOLD: prdata = {2'd0, init_threshold};
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg.scale     = window_scale;
  assign cfg.signed_wa = signed_wa;
  assign cfg.clamp     = clamp_limit;
  assign cfg.adv_mss   = adv_mss;

endmodule

>>> sv/trws_div.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on trws_pkg for widths and the status struct
module trws_div
  import trws_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SPACE_W-1:0] dividend,
  input  logic [15:0]        divisor,
  output logic [15:0]        remainder,
  output div_stat_t          stat
);

  logic [SPACE_W-1:0]   dvd;
  logic [15:0]          dsr;
  logic [15:0]          rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [16:0]          trial;
  logic [16:0]          diff;

  // one restoring step
  assign trial = {rem, dvd[SPACE_W-1]};
  assign diff  = trial - {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= 16'd0;
    end else if (busy) begin
      dvd <= {dvd[SPACE_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= diff[15:0];
      end else begin
        rem <= trial[15:0];
      end
    end
  end

  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> sv/tcp_receive_window_select.sv
// top level of the receive window select block: sequencer, state, output register
// depends on trws_pkg, trws_cfg, trws_div and the assertion macro header
//
//  channel | direction | handshake               | payload
//  cfg     | write/read| psel penable pwrite     | paddr pwdata prdata
//  in      | in        | in_valid in_ready       | buf_free buf_total peer_mss
//          |           |                         | memory_pressure next_expected_seq
//  out     | out       | out_valid out_ready     | window_field zero_window quick_ack_cleared
//
// an item passes prep, space, clamp, div, choose, shrink and out before its result
// is valid; the 16-step serial remainder unit runs in div, the other states are single steps
// one item at a time; in_ready returns once the result is in the output register
// a result stalled on out_ready holds the block in its last step
// rst is synchronous; state resets to window 65535, sequence 0, threshold 65535
`include "tcp_receive_window_select_assert.svh"
module tcp_receive_window_select
  import trws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [29:0] buf_free,
  input  logic [29:0] buf_total,
  input  logic [15:0] peer_mss,
  input  logic        memory_pressure,
  input  logic [31:0] next_expected_seq,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] window_field,
  output logic        zero_window,
  output logic        quick_ack_cleared
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_SPACE  = 3'd2;
  localparam logic [2:0] S_CLAMP  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_CHOOSE = 3'd5;
  localparam logic [2:0] S_SHRINK = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  cfg_t      cfg;
  div_stat_t div_stat;

  logic [2:0]  state;
  logic [2:0]  state_next;

  // connection state
  logic [31:0] offered_window;
  logic [31:0] window_update_seq;
  logic [15:0] slow_threshold;

  // captured item and intermediate values
  logic [29:0] free_r;
  logic [29:0] full_in_r;
  logic [15:0] mss_in_r;
  logic        pressure_r;
  logic [31:0] nseq_r;
  logic [29:0] full;
  logic [31:0] cur;
  logic [15:0] mss;
  logic        quick;
  logic        zero_early;
  logic [15:0] space;
  logic [31:0] win_raw;
  logic [31:0] win;

  logic [15:0] remainder;
  logic        div_start;
  logic        out_load;

  // combinational helpers
  logic [31:0] seq_sum;
  logic [15:0] mss_lim;
  logic        quick_c;
  logic [17:0] pressure_cap;
  logic [15:0] space_c;
  logic [31:0] unit_mask;
  logic [31:0] space_up;
  logic [16:0] space_less_mss;
  logic        keep_le;
  logic        keep_gt;
  logic [32:0] grow_sum;
  logic        grow;
  logic [31:0] win_choose;
  logic [31:0] cur_up;
  logic [31:0] win_shrink;
  logic [31:0] win_shift;
  logic [15:0] field_c;

  trws_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trws_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (space_c),
    .divisor   (mss),
    .remainder (remainder),
    .stat      (div_stat)
  );

  assign in_ready  = (state == S_IDLE);
  assign div_start = (state == S_CLAMP);
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  // remaining offer, zero once the peer passed the right edge
  assign seq_sum = window_update_seq + offered_window - nseq_r;

  // mss limit, quick-ack test and pressure cap
  assign mss_lim      = ({14'd0, mss_in_r} > full) ? full[15:0] : mss_in_r;
  assign quick_c      = (free_r < {1'b0, full[29:1]});
  assign pressure_cap = {2'd0, cfg.adv_mss} << PRESSURE_MSS_SHIFT;

  // space limited by threshold
  assign space_c = (free_r > {14'd0, slow_threshold}) ? slow_threshold : free_r[15:0];

  // scale unit rounding
  assign unit_mask = (32'h1 << cfg.scale) - 32'h1;
  assign space_up  = ({16'd0, space} + unit_mask) & ~unit_mask;

  // mss rounding tests against the current offer
  assign space_less_mss = {1'b0, space} - {1'b0, mss};
  assign keep_le  = !space_less_mss[16] && (offered_window <= {16'd0, space_less_mss[15:0]});
  assign keep_gt  = offered_window > {16'd0, space};
  assign grow_sum = {1'b0, offered_window} + {4'd0, full[29:1]};
  assign grow     = ({14'd0, mss} == full) && ({17'd0, space} > grow_sum);

  // raw window choice
  always_comb begin
    if (zero_early) begin
      win_choose = 32'd0;
    end else if (cfg.scale != 4'd0) begin
      win_choose = space_up;
    end else if (keep_le || keep_gt) begin
      if (mss == 16'd0) begin
        win_choose = 32'd0;
      end else begin
        win_choose = {16'd0, space - remainder};
      end
    end else if (grow) begin
      win_choose = {16'd0, space};
    end else begin
      win_choose = offered_window;
    end
  end

  // never shrink below the remaining offer
  assign cur_up     = (cur + unit_mask) & ~unit_mask;
  assign win_shrink = (win_raw < cur) ? cur_up : win_raw;

  // header clamp and scale shift
  assign win_shift = win >> cfg.scale;
  always_comb begin
    if (cfg.scale == 4'd0 && cfg.signed_wa) begin
      field_c = (win > {16'd0, SIGNED_WINDOW_MAX}) ? SIGNED_WINDOW_MAX : win[15:0];
    end else begin
      field_c = (win_shift[31:16] != 16'd0) ? HEADER_WINDOW_MAX : win_shift[15:0];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_PREP;
      S_PREP:   state_next = S_SPACE;
      S_SPACE:  state_next = S_CLAMP;
      S_CLAMP:  state_next = S_DIV;
      S_DIV:    if (div_stat.done) state_next = S_CHOOSE;
      S_CHOOSE: state_next = S_SHRINK;
      S_SHRINK: state_next = S_OUT;
      S_OUT:    if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // connection state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      offered_window    <= {2'd0, RESET_INIT_WIN};
      window_update_seq <= 32'd0;
      slow_threshold    <= RESET_INIT_THR[15:0];
    end else begin
      if (state == S_SPACE && quick_c && pressure_r
          && pressure_cap < {2'd0, slow_threshold}) begin
        slow_threshold <= pressure_cap[15:0];
      end
      if (state == S_SHRINK) begin
        offered_window    <= win_shrink;
        window_update_seq <= nseq_r;
      end
    end
  end

  // item capture and intermediate registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      free_r     <= buf_free;
      full_in_r  <= buf_total;
      mss_in_r   <= peer_mss;
      pressure_r <= memory_pressure;
      nseq_r     <= next_expected_seq;
    end
    case (state)
      S_PREP: begin
        full <= (full_in_r < cfg.clamp) ? full_in_r : cfg.clamp;
        cur  <= seq_sum[31] ? 32'd0 : seq_sum;
      end
      S_SPACE: begin
        mss        <= mss_lim;
        quick      <= quick_c;
        zero_early <= quick_c && ({14'd0, mss_lim} > free_r);
      end
      S_CLAMP:  space   <= space_c;
      S_CHOOSE: win_raw <= win_choose;
      S_SHRINK: win     <= win_shrink;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      window_field      <= field_c;
      zero_window       <= (field_c == 16'd0);
      quick_ack_cleared <= quick;
    end
  end

  `TRWS_ASSERT_IMPL(a_zero_flag, out_valid, zero_window == (window_field == 16'd0))
  `TRWS_ASSERT_NEXT(a_no_shrink, state == S_SHRINK, offered_window >= $past(cur))
  `TRWS_ASSERT_IMPL(a_div_done_in_div, div_stat.done, state == S_DIV)
  `TRWS_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == S_PREP && !div_stat.busy)

endmodule

>>> bench/trws_window_checker.sv
// checker for the receive window select block: tracks register writes and state,
// predicts each window result and compares it with what the block returns
// depends on trws_pkg for register indexes, reset values and header limits
module trws_window_checker
  import trws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [29:0] buf_free,
  input  logic [29:0] buf_total,
  input  logic [15:0] peer_mss,
  input  logic        memory_pressure,
  input  logic [31:0] next_expected_seq,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] window_field,
  input  logic        zero_window,
  input  logic        quick_ack_cleared,
  output int          mismatches,
  output int          windows_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] window;
    logic        zero;
    logic        quick;
  } window_result_t;

  // register copies; the initial window and threshold registers are not tracked, the block never reads them
  logic [3:0]  scale;
  logic        signed_wa;
  logic [29:0] win_clamp;
  logic [15:0] adv_mss;

  // connection state
  logic [31:0] offer_win;
  logic [31:0] wup_seq;
  logic [31:0] slow_thr;

  window_result_t pending_windows[$];
  window_result_t want;

  initial begin
    mismatches = 0;
    windows_due = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t: window mismatch: %s", $realtime, msg);
  endtask

  // window choice for one segment, updates the connection state
  function automatic window_result_t next_window(input logic [29:0] free_in,
                                                 input logic [29:0] full_in,
                                                 input logic [15:0] mss_in,
                                                 input logic pressure,
                                                 input logic [31:0] seq_in);
    window_result_t res;
    logic [31:0] remaining, win, unit, hdr_cap, down, pcap, space32;
    longint full, mss, space, offer;
    logic quick, closed;
    remaining = wup_seq + offer_win - seq_in;
    if (remaining[31]) remaining = 32'd0;
    full = (full_in < win_clamp) ? full_in : win_clamp;
    mss = mss_in;
    space = free_in;
    quick = 1'b0;
    closed = 1'b0;
    win = 32'd0;
    if (mss > full) mss = full;

    // free space under half of the buffer ends quick-ack
    if (space < (full >> 1)) begin
      quick = 1'b1;
      if (pressure) begin
        pcap = 32'(adv_mss) << PRESSURE_MSS_SHIFT;
        if (pcap < slow_thr) slow_thr = pcap;
      end
      if (space < mss) closed = 1'b1;
    end

    if (!closed) begin
      if (space > longint'(slow_thr)) space = slow_thr;
      if (scale != 4'd0) begin
        // round up to the scale unit
        space32 = space[31:0];
        down = (space32 >> scale) << scale;
        if (down != space32) down = ((space32 >> scale) + 32'd1) << scale;
        win = down;
      end else begin
        // mss rounding with silly-window avoidance
        offer = offer_win;
        if (offer <= space - mss || offer > space) begin
          offer = (mss == 0) ? 0 : (space / mss) * mss;
        end else if (mss == full && space > offer + (full >> 1)) begin
          offer = space;
        end
        win = offer[31:0];
      end
    end

    // never shrink below what is still offered
    if (win < remaining) begin
      unit = 32'd1 << scale;
      win = (remaining + unit - 32'd1) & ~(unit - 32'd1);
    end
    offer_win = win;
    wup_seq = seq_in;

    hdr_cap = (scale == 4'd0 && signed_wa) ? 32'(SIGNED_WINDOW_MAX)
                                           : (32'(HEADER_WINDOW_MAX) << scale);
    if (win > hdr_cap) win = hdr_cap;
    win = win >> scale;
    res.window = win[15:0];
    res.zero = (win == 32'd0);
    res.quick = quick;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      scale = 4'd0;
      signed_wa = 1'b0;
      win_clamp = RESET_CLAMP;
      adv_mss = RESET_ADV_MSS;
      offer_win = 32'(RESET_INIT_WIN);
      wup_seq = 32'd0;
      slow_thr = 32'(RESET_INIT_THR);
      pending_windows.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_WINDOW_SCALE:   scale = pwdata[3:0];
          REG_SIGNED_WA:      signed_wa = pwdata[0];
          REG_WINDOW_CLAMP:   win_clamp = pwdata[29:0];
          REG_ADV_MSS:        adv_mss = pwdata[15:0];
          default: ;
        endcase
      end

      // returned item against the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_windows.size() == 0) begin
          report_mismatch("result with no segment waiting");
        end else begin
          want = pending_windows.pop_front();
          if (window_field !== want.window)
            report_mismatch($sformatf("window_field got %0d want %0d",
                                      window_field, want.window));
          if (zero_window !== want.zero)
            report_mismatch($sformatf("zero_window got %b want %b",
                                      zero_window, want.zero));
          if (quick_ack_cleared !== want.quick)
            report_mismatch($sformatf("quick_ack_cleared got %b want %b",
                                      quick_ack_cleared, want.quick));
        end
      end

      // accepted segment
      if (in_valid && in_ready)
        pending_windows.push_back(next_window(buf_free, buf_total, peer_mss,
                                              memory_pressure, next_expected_seq));
    end
    windows_due = pending_windows.size();
  end

endmodule

>>> bench/tb_tcp_receive_window_select.sv
// testbench top for the receive window select block: clock, reset, register writes,
// segment stimulus with random gaps and stalls, and the final verdict
// depends on trws_pkg, the block itself and trws_window_checker
module tb_tcp_receive_window_select;
  import trws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic [29:0] buf_free, buf_total;
  logic [15:0] peer_mss;
  logic        memory_pressure;
  logic [31:0] next_expected_seq;
  logic        out_valid, out_ready;
  logic [15:0] window_field;
  logic        zero_window, quick_ack_cleared;
  int          mismatches;
  int          windows_due;

  // idling controls for sender and receiver, and the sequence last sent
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  bit          stall_long = 1'b0;
  logic [31:0] seq_now = 32'd0;

  always #5 clk = ~clk;

  tcp_receive_window_select i_dut (.*);

  trws_window_checker i_checker (.*);

  // run limit
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_item(input logic [29:0] fr, input logic [29:0] fu,
                           input logic [15:0] ms, input logic pr, input logic [31:0] sq);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    buf_free <= fr;
    buf_total <= fu;
    peer_mss <= ms;
    memory_pressure <= pr;
    next_expected_seq <= sq;
    in_valid <= 1'b1;
    seq_now = sq;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // stop offering items until every predicted window has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (windows_due != 0);
  endtask

  // mostly plausible segments with an advancing sequence, some raw noise
  task automatic send_random();
    int unsigned pick;
    logic [29:0] fu, fr;
    logic [15:0] ms;
    logic [31:0] sq;
    logic pr;
    pick = $urandom_range(0, 9);
    pr = ($urandom_range(0, 3) == 0);
    sq = seq_now + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 70000));
    if (pick < 7) begin
      fu = 30'($urandom_range(1000, 131071));
      fr = 30'($urandom_range(0, fu));
      ms = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 9000)) : 16'd1460;
    end else if (pick == 7) begin
      // mss equal to the full space
      ms = 16'($urandom_range(200, 4000));
      fu = 30'(ms);
      fr = 30'($urandom_range(0, 70000));
    end else begin
      fu = 30'($urandom());
      fr = 30'($urandom());
      ms = 16'($urandom());
      sq = $urandom();
    end
    send_item(fr, fu, ms, pr, sq);
  endtask

  task automatic run_phase(input int count, input bit long_hold);
    int unsigned mode;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        mode = $urandom_range(0, 3);
        tx_idle = mode[0];
        rx_idle = mode[1];
      end
      if (long_hold && i == 20) stall_long = 1'b1;
      if (i == count / 2) wait_drained();
      send_random();
    end
    wait_drained();
  endtask

  // receiver: random stalls, one long hold on request
  initial begin : receiver
    int unsigned gap;
    out_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (stall_long) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        stall_long = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    buf_free = '0;
    buf_total = '0;
    peer_mss = '0;
    memory_pressure = 1'b0;
    next_expected_seq = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // large own mss keeps the threshold whole in the early phases
    write_reg(REG_ADV_MSS, 32'd65535);

    // all zero, then every field at its top
    send_item(30'd0, 30'd0, 16'd0, 1'b0, 32'd0);
    send_item(30'h3FFF_FFFF, 30'h3FFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    // typical segment, then same edge so the offer is kept
    send_item(30'd60000, 30'd65535, 16'd1460, 1'b0, 32'd1000);
    send_item(30'd30000, 30'd65535, 16'd1460, 1'b0, 32'd1000);
    // zero mss without scaling
    send_item(30'd40000, 30'd65535, 16'd0, 1'b0, 32'd2000);
    // mss larger than the usable space
    send_item(30'd100, 30'd200, 16'd1460, 1'b0, 32'd2100);
    // free space under half and under one mss chooses a zero raw window
    send_item(30'd500, 30'd60000, 16'd1460, 1'b0, 32'd2200);
    send_item(30'd500, 30'd60000, 16'd1460, 1'b1, 32'd2300);
    // sequence beyond the offered right edge
    send_item(30'd20000, 30'd65535, 16'd536, 1'b0, 32'h4000_0000);
    // mss equal to full space
    send_item(30'd3000, 30'd2000, 16'd2000, 1'b0, 32'h4000_0100);
    // alternating bit patterns
    send_item(30'h2AAA_AAAA, 30'h1555_5555, 16'hAAAA, 1'b0, 32'h5555_5555);
    send_item(30'h1555_5555, 30'h2AAA_AAAA, 16'h5555, 1'b1, 32'hAAAA_AAAA);
    wait_drained();

    // signed window workaround without scaling
    write_reg(REG_SIGNED_WA, 32'd1);
    send_item(30'd65535, 30'd65535, 16'd1460, 1'b0, 32'hAAAA_AAAA);
    send_item(30'd50000, 30'd65535, 16'd1000, 1'b0, 32'hAAAA_C000);
    wait_drained();

    // scale fifteen
    write_reg(REG_SIGNED_WA, 32'd0);
    write_reg(REG_WINDOW_SCALE, 32'd15);
    send_item(30'd65535, 30'd65535, 16'd1460, 1'b0, 32'hAAAB_0000);
    send_item(30'd1, 30'd65535, 16'd0, 1'b0, 32'hAAAC_0000);
    send_item(30'h3FFF_FFFF, 30'h3FFF_FFFF, 16'd1460, 1'b0, 32'hAAAC_0000);
    wait_drained();

    // plain window, default clamp
    write_reg(REG_WINDOW_SCALE, 32'd0);
    run_phase(110, 1'b0);

    // workaround on, widest clamp, initial registers at their extremes
    write_reg(REG_SIGNED_WA, 32'd1);
    write_reg(REG_WINDOW_CLAMP, 32'h3FFF_FFFF);
    write_reg(REG_INIT_WINDOW, 32'h3FFF_FFFF);
    write_reg(REG_INIT_THRESHOLD, 32'd0);
    run_phase(120, 1'b0);

    // largest agreed scale with a long receiver hold
    write_reg(REG_WINDOW_SCALE, 32'd14);
    write_reg(REG_WINDOW_CLAMP, 32'h0010_0000);
    run_phase(120, 1'b1);

    // scale fifteen with a zero clamp
    write_reg(REG_WINDOW_SCALE, 32'd15);
    write_reg(REG_SIGNED_WA, 32'd0);
    write_reg(REG_WINDOW_CLAMP, 32'd0);
    run_phase(40, 1'b0);

    // pressure now pulls the threshold down in steps
    write_reg(REG_WINDOW_SCALE, 32'd7);
    write_reg(REG_WINDOW_CLAMP, 32'd30000);
    write_reg(REG_ADV_MSS, 32'd8000);
    run_phase(120, 1'b0);

    write_reg(REG_WINDOW_SCALE, 32'd0);
    write_reg(REG_WINDOW_CLAMP, 32'd65535);
    write_reg(REG_ADV_MSS, 32'd1460);
    run_phase(120, 1'b0);

    write_reg(REG_WINDOW_SCALE, 32'd3);
    write_reg(REG_WINDOW_CLAMP, 32'h3FFF_FFFF);
    write_reg(REG_ADV_MSS, 32'd0);
    write_reg(REG_INIT_WINDOW, 32'd0);
    write_reg(REG_INIT_THRESHOLD, 32'h3FFF_FFFF);
    run_phase(120, 1'b0);

    // allow for a stray late result
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
